### rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
// Used by lfu_cmp and lfu_cache_table_unit; depends on nothing else.
package lfu_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int COUNT_BITS  = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CAP_W > OCC_W) ? CAP_W : OCC_W;
  localparam int WORD_W      = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Command codes carried on s_tuser
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // One stored entry as seen by the compare unit
  typedef struct packed {
    logic                  valid;
    logic [WORD_W-1:0]     key;
    logic [COUNT_BITS-1:0] count;
    logic [IDX_W-1:0]      rank;
  } entry_t;

  // Current eviction candidate
  typedef struct packed {
    logic                  found;
    logic [COUNT_BITS-1:0] count;
    logic [IDX_W-1:0]      rank;
  } best_t;

  // Compare unit verdict
  typedef struct packed {
    logic match;
    logic better;
  } cmp_t;

endpackage

### rtl/lfu_cache_table_unit.sv
// LFU cache table top level: entry storage, scan sequencer and stream ports.
// Depends on lfu_pkg and lfu_cmp.
//
// Fully associative key/value table with least-frequently-used replacement,
// ties going to the least recently used entry. Each transaction on the input
// stream is a get (s_tuser = 0) or a set (s_tuser = 1) and produces exactly one
// output transaction carrying the hit flag and the read value (-1 on a get
// miss, 0 for any set). After acceptance the block walks all MAX_ENTRIES
// slots through one shared compare unit, one slot per cycle, looking for the
// key, the eviction victim and the first free slot, then performs the update.
// No new transaction is accepted until that update is done. The result sits
// in an output register, so the next transaction is accepted while it waits;
// that next update stalls only while the earlier result is still not taken.
// capacity (cfg_wdata) must be written only while the block is idle, which
// the block itself does not enforce; 0 acts as 1 and values above MAX_ENTRIES
// act as MAX_ENTRIES.
module lfu_cache_table_unit
  import lfu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,   // capacity
  // input stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [63:0]      s_tdata,     // [31:0] key, [63:32] value
  input  logic             s_tuser,     // command
  // output stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,     // read_value
  output logic             m_tuser      // hit
);

  // storage
  logic                  ent_valid [MAX_ENTRIES];
  logic [WORD_W-1:0]     ent_key   [MAX_ENTRIES];
  logic [WORD_W-1:0]     ent_value [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] ent_count [MAX_ENTRIES];
  logic [IDX_W-1:0]      ent_rank  [MAX_ENTRIES];
  logic [OCC_W-1:0]      occ;
  logic [CAP_W-1:0]      capacity;

  // sequencer
  state_t           state, state_next;
  logic [IDX_W-1:0] idx;
  logic             scan_last;
  logic             out_free;
  logic             in_fire;
  logic             scan_en;
  logic             upd_fire;

  // latched transaction
  logic              cmd_q;
  logic [WORD_W-1:0] key_q;
  logic [WORD_W-1:0] val_q;

  // scan results
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_slot;
  logic [COUNT_BITS-1:0] hit_count;
  logic [IDX_W-1:0]      hit_rank;
  best_t                 vic;
  logic [IDX_W-1:0]      vic_slot;
  logic                  free_found;
  logic [IDX_W-1:0]      free_slot;

  entry_t cand;
  cmp_t   cmp_res;

  // update decode
  logic                  do_ins;
  logic                  do_evict;
  logic                  do_rank;
  logic [IDX_W-1:0]      slot;
  logic [IDX_W-1:0]      dec_ref;
  logic [IDX_W-1:0]      new_rank;
  logic [COUNT_BITS-1:0] new_count;
  logic [CMP_W-1:0]      cap_x;
  logic [CMP_W-1:0]      eff_cap;
  logic [WORD_W-1:0]     rd_value;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_W'(16);
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_comb begin
    cap_x = CMP_W'(capacity);
    if (cap_x == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_x > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_x;
    end
  end

  // handshake and control
  assign out_free  = !m_tvalid || m_tready;
  assign scan_last = (idx == IDX_W'(MAX_ENTRIES - 1));
  assign in_fire   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_UPDATE;
      ST_UPDATE: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    scan_en  = (state == ST_SCAN);
    upd_fire = (state == ST_UPDATE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (in_fire || upd_fire) begin
        idx <= '0;
      end else if (scan_en && !scan_last) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // capture the transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q <= s_tuser;
      key_q <= s_tdata[31:0];
      val_q <= s_tdata[63:32];
    end
  end

  // shared compare unit fed by the scan index
  always_comb begin
    cand.valid = ent_valid[idx];
    cand.key   = ent_key[idx];
    cand.count = ent_count[idx];
    cand.rank  = ent_rank[idx];
  end

  lfu_cmp u_cmp (
    .cand (cand),
    .best (vic),
    .key  (key_q),
    .res  (cmp_res)
  );

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst || in_fire) begin
      hit_found  <= 1'b0;
      vic.found  <= 1'b0;
      free_found <= 1'b0;
    end else if (scan_en) begin
      if (cmp_res.match && !hit_found) begin
        hit_found <= 1'b1;
        hit_slot  <= idx;
        hit_count <= cand.count;
        hit_rank  <= cand.rank;
      end
      if (cmp_res.better) begin
        vic.found <= 1'b1;
        vic.count <= cand.count;
        vic.rank  <= cand.rank;
        vic_slot  <= idx;
      end
      if (!cand.valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= idx;
      end
    end
  end

  // update decode
  always_comb begin
    do_ins   = !hit_found && (cmd_q == CMD_SET);
    do_evict = do_ins && ((CMP_W'(occ) >= eff_cap) || !free_found);
    do_rank  = hit_found || do_ins;
    if (hit_found) begin
      slot = hit_slot;
    end else if (do_evict) begin
      slot = vic_slot;
    end else begin
      slot = free_slot;
    end
    dec_ref = hit_found ? hit_rank : vic.rank;
    if (hit_found || do_evict) begin
      new_rank = IDX_W'(occ - OCC_W'(1));
    end else begin
      new_rank = IDX_W'(occ);
    end
    if (hit_found) begin
      new_count = (hit_count == COUNT_MAX) ? hit_count : hit_count + COUNT_BITS'(1);
    end else begin
      new_count = COUNT_BITS'(1);
    end
  end

  // entry storage update
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        ent_valid[i] <= 1'b0;
      end
    end else if (upd_fire && do_rank) begin
      if (do_ins && !do_evict) begin
        occ <= occ + OCC_W'(1);
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          ent_valid[i] <= 1'b1;
          ent_rank[i]  <= new_rank;
          ent_count[i] <= new_count;
          if (cmd_q == CMD_SET) begin
            ent_value[i] <= val_q;
          end
          if (do_ins) begin
            ent_key[i] <= key_q;
          end
        end else if ((hit_found || do_evict) && ent_valid[i] &&
                     (ent_rank[i] > dec_ref)) begin
          ent_rank[i] <= ent_rank[i] - IDX_W'(1);
        end
      end
    end
  end

  // result select
  always_comb begin
    if (cmd_q == CMD_SET) begin
      rd_value = '0;
    end else if (hit_found) begin
      rd_value = ent_value[hit_slot];
    end else begin
      rd_value = '1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (upd_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      m_tdata <= rd_value;
      m_tuser <= hit_found;
    end
  end

endmodule

### rtl/lfu_cmp.sv
// Shared compare unit: key match and victim ordering for one entry per cycle.
// Depends on lfu_pkg.
module lfu_cmp
  import lfu_pkg::*;
(
  input  entry_t            cand,
  input  best_t             best,
  input  logic [WORD_W-1:0] key,
  output cmp_t              res
);

  logic cnt_lt;
  logic cnt_eq;

  assign cnt_lt = cand.count < best.count;
  assign cnt_eq = cand.count == best.count;

  // Lower count wins; on equal counts the older entry wins
  always_comb begin
    res.match  = cand.valid && (cand.key == key);
    res.better = cand.valid &&
                 (!best.found || cnt_lt || (cnt_eq && (cand.rank < best.rank)));
  end

endmodule
